@@ rtl/mta_pkg.sv @@
// shared constants, codes and control types of the thread accounting unit
package mta_pkg;

   localparam int SLOTS         = 64;
   localparam int SLOT_W        = 6;
   localparam int FRAC_BITS     = 14;
   localparam int ONE           = 1 << FRAC_BITS;
   localparam int MAX_PRIO      = 63;
   localparam int MIN_PRIO      = 0;
   localparam int RC_W          = 32;
   localparam int NICE_W        = 6;
   localparam int PRIO_W        = 6;
   localparam int COUNT_W       = 7;
   localparam int LOAD_W        = 21;
   localparam int COEF_W        = 15;
   localparam int DIV_W         = 36;
   localparam int DVS_W         = 24;
   localparam int ENTRY_W       = RC_W + NICE_W + PRIO_W;
   localparam int RC_X100_W     = 25;
   localparam int LOAD_X100_W   = 13;
   localparam int RC_X100_LIMIT = 13107100;
   localparam int LOAD_X100_LIMIT = 8191;
   localparam int NICE_LOW      = -20;
   localparam int NICE_HIGH     = 20;

   // request function codes
   localparam logic [2:0] FUNC_TICK      = 3'd0;
   localparam logic [2:0] FUNC_REFRESH   = 3'd1;
   localparam logic [2:0] FUNC_SET_NICE  = 3'd2;
   localparam logic [2:0] FUNC_RECOMPUTE = 3'd3;
   localparam logic [2:0] FUNC_CREATE    = 3'd4;
   localparam logic [2:0] FUNC_RETIRE    = 3'd5;
   localparam logic [2:0] FUNC_READ      = 3'd6;
   localparam logic [2:0] FUNC_NONE      = 3'd7;

   // divider operand selects, in refresh order
   localparam logic [1:0] DIV_LOAD59 = 2'd0;
   localparam logic [1:0] DIV_COUNT  = 2'd1;
   localparam logic [1:0] DIV_COEF   = 2'd2;

   typedef struct packed {
      logic       latch;
      logic [2:0] op;
      logic       addr_clr;
      logic       addr_inc;
      logic       div_start;
      logic [1:0] div_sel;
      logic       div_take;
      logic       ram_rd;
      logic       work_load;
      logic       mul_coef;
      logic       rc_upd;
      logic       op_mod;
      logic       prio_wr;
      logic       x100_mul;
      logic       blank;
      logic       emit;
      logic       last;
   } mta_cmd_type;

   typedef struct packed {
      logic div_done;
      logic any_elig;
      logic cur_elig;
      logic more_elig;
   } mta_status_type;

endpackage

@@ rtl/mta_ram.sv @@
// generic single write port ram with registered read
module mta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

@@ rtl/mta_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
module mta_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [mta_pkg::DIV_W-1:0] dividend,
   input  logic [mta_pkg::DVS_W-1:0] divisor,
   output logic                      done,
   output logic [mta_pkg::DIV_W-1:0] quotient
);
   import mta_pkg::*;

   logic [DVS_W-1:0] rem_ff, rem_in, dvs_ff;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in, done_ff, done_in;
   logic [DVS_W:0]   rem_sh;
   logic             ge;

   // one shift and subtract step
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[DIV_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         cnt_in = 6'(DIV_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? DVS_W'(rem_sh - {1'b0, dvs_ff}) : DVS_W'(rem_sh);
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ rtl/mta_datapath.sv @@
// slot table, load average, fixed point arithmetic and result registers
module mta_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  mta_pkg::mta_cmd_type               cmd,
   output mta_pkg::mta_status_type            st,
   input  logic [mta_pkg::SLOT_W-1:0]         req_slot,
   input  logic signed [mta_pkg::NICE_W-1:0]  req_nice_value,
   input  logic [mta_pkg::COUNT_W-1:0]        req_ready_count,
   input  logic                               csr_wr_en,
   input  logic [mta_pkg::SLOT_W-1:0]         csr_wr_data,
   output logic                               rsp_strobe,
   output logic [mta_pkg::SLOT_W-1:0]         rsp_out_slot,
   output logic [mta_pkg::PRIO_W-1:0]         rsp_out_priority,
   output logic signed [mta_pkg::RC_X100_W-1:0] rsp_recent_cpu_x100,
   output logic [mta_pkg::LOAD_X100_W-1:0]    rsp_load_avg_x100,
   output logic                               rsp_last
);
   import mta_pkg::*;

   // control and configuration registers
   logic [SLOT_W-1:0]  idle_ff, addr_ff;
   logic [SLOTS-1:0]   valid_ff;
   logic [LOAD_W-1:0]  load_ff, acc_ff;
   logic [COEF_W-1:0]  coef_ff;
   logic [COUNT_W-1:0] count_ff;
   logic signed [NICE_W-1:0] nice_req_ff;

   // working copy of one slot
   logic signed [RC_W-1:0]   rc_ff, rc_in;
   logic signed [NICE_W-1:0] nice_ff, nice_in;
   logic [PRIO_W-1:0]        prio_ff, prio_in;
   logic                     vld_ff, vld_in;

   // products
   logic signed [47:0] prod_ff;
   logic signed [39:0] rcx_ff;
   logic [27:0]        loadx_ff;
   logic [SLOT_W-1:0]  slot_p_ff;
   logic [PRIO_W-1:0]  prio_p_ff;

   // result registers
   logic                         strobe_ff;
   logic [SLOT_W-1:0]            out_slot_ff;
   logic [PRIO_W-1:0]            out_prio_ff;
   logic signed [RC_X100_W-1:0]  out_rc_ff, out_rc_in;
   logic [LOAD_X100_W-1:0]       out_load_ff, out_load_in;
   logic                         out_last_ff;

   logic [ENTRY_W-1:0] rd_data, wr_data;
   logic [DIV_W-1:0]   div_dividend, quotient;
   logic [DVS_W-1:0]   div_divisor;
   logic               div_done;
   logic [21:0]        two_load;

   logic signed [NICE_W-1:0] nice_clamp;
   logic [COUNT_W-1:0]       count_clamp;
   logic signed [34:0]       rcsum;
   logic signed [32:0]       ticksum;
   logic signed [33:0]       rc_q;
   logic signed [35:0]       p_full, p_int;
   logic [PRIO_W-1:0]        prio_new;
   logic                     do_recompute;
   logic [39:0]              rc_mag, rc_round;
   logic [27:0]              load_round;
   logic [SLOTS-1:0]         elig, above;

   mta_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_table (
      .clock   (clock),
      .wr_en   (cmd.prio_wr),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.ram_rd),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // divider operand select
   always_comb begin
      two_load = {load_ff, 1'b0};
      case (cmd.div_sel)
         DIV_LOAD59: begin
            div_dividend = DIV_W'(load_ff) * DIV_W'(59);
            div_divisor  = DVS_W'(60);
         end
         DIV_COUNT: begin
            div_dividend = DIV_W'(count_ff) << FRAC_BITS;
            div_divisor  = DVS_W'(60);
         end
         default: begin
            div_dividend = DIV_W'(two_load) << FRAC_BITS;
            div_divisor  = DVS_W'(two_load) + DVS_W'(ONE);
         end
      endcase
   end

   mta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // request field conditioning
   always_comb begin
      if (req_nice_value < NICE_W'(NICE_LOW)) begin
         nice_clamp = NICE_W'(NICE_LOW);
      end else if (req_nice_value > NICE_W'(NICE_HIGH)) begin
         nice_clamp = NICE_W'(NICE_HIGH);
      end else begin
         nice_clamp = req_nice_value;
      end
      count_clamp = (req_ready_count > COUNT_W'(SLOTS)) ? COUNT_W'(SLOTS) : req_ready_count;
   end

   // eligibility over the valid bits
   always_comb begin
      elig         = valid_ff & ~(SLOTS'(1) << idle_ff);
      above        = ({SLOTS{1'b1}} << addr_ff) << 1;
      st.div_done  = div_done;
      st.any_elig  = |elig;
      st.cur_elig  = elig[addr_ff];
      st.more_elig = |(elig & above);
   end

   // slot arithmetic
   always_comb begin
      rcsum   = 35'(prod_ff >>> FRAC_BITS) + (35'(nice_ff) <<< FRAC_BITS);
      ticksum = 33'(rc_ff) + 33'(ONE);
      rc_q    = (34'(rc_ff) + (rc_ff[RC_W-1] ? 34'sd3 : 34'sd0)) >>> 2;
      p_full  = 36'(MAX_PRIO * ONE) - 36'(rc_q) - (36'(nice_ff) <<< (FRAC_BITS + 1));
      p_int   = p_full >>> FRAC_BITS;
      if (p_int < 36'(MIN_PRIO)) begin
         prio_new = PRIO_W'(MIN_PRIO);
      end else if (p_int > 36'(MAX_PRIO)) begin
         prio_new = PRIO_W'(MAX_PRIO);
      end else begin
         prio_new = p_int[PRIO_W-1:0];
      end
      case (cmd.op) inside
         FUNC_REFRESH, FUNC_SET_NICE, FUNC_RECOMPUTE, FUNC_CREATE:
            do_recompute = vld_ff && (addr_ff != idle_ff);
         default: do_recompute = 1'b0;
      endcase
   end

   // working copy next values
   always_comb begin
      rc_in   = rc_ff;
      nice_in = nice_ff;
      prio_in = prio_ff;
      vld_in  = vld_ff;
      if (cmd.work_load) begin
         vld_in  = valid_ff[addr_ff];
         rc_in   = valid_ff[addr_ff] ? rd_data[ENTRY_W-1 -: RC_W] : '0;
         nice_in = valid_ff[addr_ff] ? rd_data[PRIO_W +: NICE_W] : '0;
         prio_in = valid_ff[addr_ff] ? rd_data[PRIO_W-1:0] : '0;
      end else if (cmd.rc_upd) begin
         if (rcsum > 35'sd2147483647) begin
            rc_in = 32'sh7FFFFFFF;
         end else if (rcsum < -35'sd2147483648) begin
            rc_in = 32'sh80000000;
         end else begin
            rc_in = rcsum[RC_W-1:0];
         end
      end else if (cmd.op_mod) begin
         case (cmd.op)
            FUNC_TICK: begin
               if (vld_ff && addr_ff != idle_ff) begin
                  rc_in = (ticksum > 33'sd2147483647) ? 32'sh7FFFFFFF : ticksum[RC_W-1:0];
               end
            end
            FUNC_SET_NICE: begin
               if (vld_ff) begin
                  nice_in = nice_req_ff;
               end
            end
            FUNC_CREATE: begin
               rc_in   = '0;
               nice_in = '0;
               prio_in = PRIO_W'(MIN_PRIO);
               vld_in  = 1'b1;
            end
            FUNC_RETIRE: begin
               rc_in   = '0;
               nice_in = '0;
               prio_in = '0;
               vld_in  = 1'b0;
            end
            default: ;
         endcase
      end else if (cmd.prio_wr && do_recompute) begin
         prio_in = prio_new;
      end
   end

   assign wr_data = {rc_ff, nice_ff, (do_recompute ? prio_new : prio_ff)};

   // rounding of the x100 products
   always_comb begin
      rc_mag     = rcx_ff[39] ? 40'(-rcx_ff) : 40'(rcx_ff);
      rc_round   = (rc_mag + 40'd8192) >> FRAC_BITS;
      if (rc_round > 40'(RC_X100_LIMIT)) begin
         rc_round = 40'(RC_X100_LIMIT);
      end
      out_rc_in  = rcx_ff[39] ? -RC_X100_W'(rc_round) : RC_X100_W'(rc_round);
      load_round = (loadx_ff + 28'd8192) >> FRAC_BITS;
      out_load_in = (load_round > 28'(LOAD_X100_LIMIT)) ? LOAD_X100_W'(LOAD_X100_LIMIT)
                                                        : load_round[LOAD_X100_W-1:0];
   end

   // control state, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff   <= '0;
         valid_ff  <= '0;
         load_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            idle_ff <= csr_wr_data;
         end
         if (cmd.prio_wr) begin
            valid_ff[addr_ff] <= vld_ff;
         end
         if (cmd.div_take && cmd.div_sel == DIV_COUNT) begin
            load_ff <= acc_ff + quotient[LOAD_W-1:0];
         end
         strobe_ff <= cmd.emit;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         addr_ff     <= req_slot;
         nice_req_ff <= nice_clamp;
         count_ff    <= count_clamp;
      end else if (cmd.addr_clr) begin
         addr_ff <= '0;
      end else if (cmd.addr_inc) begin
         addr_ff <= addr_ff + SLOT_W'(1);
      end
      if (cmd.div_take && cmd.div_sel == DIV_LOAD59) begin
         acc_ff <= quotient[LOAD_W-1:0];
      end
      if (cmd.div_take && cmd.div_sel == DIV_COEF) begin
         coef_ff <= quotient[COEF_W-1:0];
      end
      rc_ff   <= rc_in;
      nice_ff <= nice_in;
      prio_ff <= prio_in;
      vld_ff  <= vld_in;
      if (cmd.mul_coef) begin
         prod_ff <= 48'($signed({1'b0, coef_ff})) * 48'(rc_ff);
      end
      if (cmd.x100_mul) begin
         rcx_ff    <= cmd.blank ? 40'sd0 : 40'(rc_ff) * 40'sd100;
         slot_p_ff <= cmd.blank ? '0 : addr_ff;
         prio_p_ff <= cmd.blank ? '0 : prio_ff;
         loadx_ff  <= 28'(load_ff) * 28'd100;
      end
      if (cmd.emit) begin
         out_slot_ff <= slot_p_ff;
         out_prio_ff <= prio_p_ff;
         out_rc_ff   <= out_rc_in;
         out_load_ff <= out_load_in;
         out_last_ff <= cmd.last;
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_out_slot        = out_slot_ff;
   assign rsp_out_priority    = out_prio_ff;
   assign rsp_recent_cpu_x100 = out_rc_ff;
   assign rsp_load_avg_x100   = out_load_ff;
   assign rsp_last            = out_last_ff;
endmodule

@@ rtl/mta_ctrl.sv @@
// request sequencer for the thread accounting unit
module mta_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [2:0]              req_func,
   output logic                    busy,
   input  mta_pkg::mta_status_type st,
   output mta_pkg::mta_cmd_type    cmd
);
   import mta_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DIV_GO, S_DIV_WAIT, S_FETCH, S_LOAD, S_MULC, S_RCUPD,
      S_OPMOD, S_PRIO, S_MUL, S_EMIT, S_NEXT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] func_ff, func_in;
   logic [1:0] phase_ff, phase_in;
   logic       blank_ff, blank_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      phase_in = phase_ff;
      blank_in = blank_ff;
      cmd      = '0;
      cmd.op   = func_ff;
      cmd.div_sel = phase_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               func_in   = req_func;
               blank_in  = 1'b0;
               if (req_func == FUNC_REFRESH) begin
                  phase_in = DIV_LOAD59;
                  state_in = S_DIV_GO;
               end else if (req_func != FUNC_NONE) begin
                  state_in = S_FETCH;
               end
            end
         end
         S_DIV_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (st.div_done) begin
               cmd.div_take = 1'b1;
               if (phase_ff == DIV_COEF) begin
                  cmd.addr_clr = 1'b1;
                  if (st.any_elig) begin
                     state_in = S_FETCH;
                  end else begin
                     blank_in = 1'b1;
                     state_in = S_MUL;
                  end
               end else begin
                  phase_in = phase_ff + 2'd1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_FETCH: begin
            cmd.ram_rd = 1'b1;
            state_in   = S_LOAD;
         end
         S_LOAD: begin
            cmd.work_load = 1'b1;
            if (func_ff == FUNC_REFRESH) begin
               state_in = st.cur_elig ? S_MULC : S_NEXT;
            end else begin
               state_in = S_OPMOD;
            end
         end
         S_MULC: begin
            cmd.mul_coef = 1'b1;
            state_in     = S_RCUPD;
         end
         S_RCUPD: begin
            cmd.rc_upd = 1'b1;
            state_in   = S_PRIO;
         end
         S_OPMOD: begin
            cmd.op_mod = 1'b1;
            state_in   = S_PRIO;
         end
         S_PRIO: begin
            cmd.prio_wr = 1'b1;
            state_in    = (func_ff == FUNC_TICK) ? S_IDLE : S_MUL;
         end
         S_MUL: begin
            cmd.x100_mul = 1'b1;
            cmd.blank    = blank_ff;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            cmd.last = (func_ff != FUNC_REFRESH) || blank_ff || !st.more_elig;
            state_in = cmd.last ? S_IDLE : S_NEXT;
         end
         S_NEXT: begin
            cmd.addr_inc = 1'b1;
            state_in     = S_FETCH;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         func_ff  <= FUNC_NONE;
         phase_ff <= DIV_LOAD59;
         blank_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         func_ff  <= func_in;
         phase_ff <= phase_in;
         blank_ff <= blank_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule

@@ rtl/mlfqs_thread_accounting_unit.sv @@
// top level of the mlfqs thread accounting unit
//
//  channel   | ports                          | handshake
//  ----------+--------------------------------+-------------------------------
//  request   | req_func/slot/nice/ready_count | word taken when start & !busy
//  response  | rsp_out_slot ... rsp_last      | rsp_strobe, one cycle, no stall
//  config    | csr_wr_data                    | csr_wr_en, written at once
//
// set nice, recompute, create, retire and read deliver one word each.
// refresh runs three divider passes, then walks the slots up to the last
// eligible one, one slot at a time through the table, skipping the slots
// that are not eligible and updating the others.
// synchronous reset clears the valid bits, load average and idle slot.
// the receiver cannot stall; a new request is taken once busy drops.
module mlfqs_thread_accounting_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_func,
   input  logic [mta_pkg::SLOT_W-1:0]           req_slot,
   input  logic signed [mta_pkg::NICE_W-1:0]    req_nice_value,
   input  logic [mta_pkg::COUNT_W-1:0]          req_ready_count,
   output logic                                 rsp_strobe,
   output logic [mta_pkg::SLOT_W-1:0]           rsp_out_slot,
   output logic [mta_pkg::PRIO_W-1:0]           rsp_out_priority,
   output logic signed [mta_pkg::RC_X100_W-1:0] rsp_recent_cpu_x100,
   output logic [mta_pkg::LOAD_X100_W-1:0]      rsp_load_avg_x100,
   output logic                                 rsp_last,
   input  logic                                 csr_wr_en,
   input  logic [mta_pkg::SLOT_W-1:0]           csr_wr_data
);
   import mta_pkg::*;

   mta_cmd_type    cmd;
   mta_status_type st;

   // sequencer
   mta_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_func (req_func),
      .busy     (busy),
      .st       (st),
      .cmd      (cmd)
   );

   // datapath
   mta_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .req_slot            (req_slot),
      .req_nice_value      (req_nice_value),
      .req_ready_count     (req_ready_count),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_out_slot        (rsp_out_slot),
      .rsp_out_priority    (rsp_out_priority),
      .rsp_recent_cpu_x100 (rsp_recent_cpu_x100),
      .rsp_load_avg_x100   (rsp_load_avg_x100),
      .rsp_last            (rsp_last)
   );

`ifndef SYNTHESIS
   // a real request keeps the unit busy in the next cycle
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func != FUNC_NONE) |=> busy)
      else $error("accepted request did not raise busy");

   // a word only comes out of work in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response word without pending request");

   // more words follow a word that is not the last one
   a_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("request finished without a last word");
`endif
endmodule

@@ tb/tb.sv @@
// testbench for the mlfqs thread accounting unit: directed and random requests, scoreboard
`timescale 1ns / 100ps

module tb;
   import mta_pkg::*;

   typedef struct {
      logic [2:0]  func;
      logic [5:0]  slot;
      logic [5:0]  nice;
      logic [6:0]  count;
   } acct_req_type;

   typedef struct {
      logic [5:0]  slot;
      logic [5:0]  prio;
      logic [24:0] rc_x100;
      logic [12:0] load_x100;
      logic        last;
   } acct_word_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [2:0]  req_func = FUNC_NONE;
   logic [5:0]  req_slot = '0;
   logic signed [5:0] req_nice_value = '0;
   logic [6:0]  req_ready_count = '0;
   logic        rsp_strobe;
   logic [5:0]  rsp_out_slot;
   logic [5:0]  rsp_out_priority;
   logic signed [24:0] rsp_recent_cpu_x100;
   logic [12:0] rsp_load_avg_x100;
   logic        rsp_last;
   logic        csr_wr_en = 0;
   logic [5:0]  csr_wr_data = '0;

   mlfqs_thread_accounting_unit dut (.*);

   always #10 clock = ~clock;

   // shadow copy of the slot table and load average
   bit      shadow_valid [SLOTS];
   longint  shadow_rc    [SLOTS];
   longint  shadow_nice  [SLOTS];
   longint  shadow_prio  [SLOTS];
   longint  shadow_load;
   int      shadow_idle;

   acct_req_type  pending_reqs [$];
   acct_word_type due_words [$];
   acct_req_type  cur;
   int  errors, n_accepted, n_words, n_refresh, idle_cycles;
   int  gap_left, burst_left;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // rounds away from zero at the half
   function automatic longint round_fixed(longint v);
      if (v >= 0) return (v + ONE / 2) >>> FRAC_BITS;
      return -(((-v) + ONE / 2) >>> FRAC_BITS);
   endfunction

   function automatic void update_priority(int s);
      longint p;
      if (s == shadow_idle) return;
      p = longint'(MAX_PRIO) * ONE - shadow_rc[s] / 4 - 2 * shadow_nice[s] * ONE;
      p = p >>> FRAC_BITS;
      if (p < MIN_PRIO) p = longint'(MIN_PRIO);
      if (p > MAX_PRIO) p = longint'(MAX_PRIO);
      shadow_prio[s] = p;
   endfunction

   function automatic void push_word(int s, bit real_slot, bit last);
      acct_word_type w;
      longint rc, ld;
      rc = 0;
      w.prio = '0;
      if (real_slot) begin
         rc = round_fixed(shadow_rc[s] * 100);
         if (rc > RC_X100_LIMIT) rc = longint'(RC_X100_LIMIT);
         if (rc < -RC_X100_LIMIT) rc = -longint'(RC_X100_LIMIT);
         w.prio = shadow_prio[s][5:0];
      end
      ld = round_fixed(shadow_load * 100);
      if (ld < 0) ld = 0;
      if (ld > LOAD_X100_LIMIT) ld = longint'(LOAD_X100_LIMIT);
      w.slot = s[5:0];
      w.rc_x100 = rc[24:0];
      w.load_x100 = ld[12:0];
      w.last = last;
      due_words.push_back(w);
   endfunction

   // applies one accepted request to the shadow state, queues its words
   function automatic void account_request(acct_req_type r);
      int s, k, first;
      longint nv, cnt, two_load, coef;
      s = int'(r.slot);
      nv = longint'($signed(r.nice));
      if (nv < NICE_LOW) nv = longint'(NICE_LOW);
      if (nv > NICE_HIGH) nv = longint'(NICE_HIGH);
      cnt = longint'(r.count);
      case (r.func)
         FUNC_TICK: begin
            if (shadow_valid[s] && s != shadow_idle)
               shadow_rc[s] = sat32(shadow_rc[s] + ONE);
         end
         FUNC_REFRESH: begin
            n_refresh++;
            if (cnt > SLOTS) cnt = longint'(SLOTS);
            shadow_load = sat32(shadow_load * 59 / 60 + cnt * ONE / 60);
            two_load = 2 * shadow_load;
            coef = two_load * ONE / (two_load + ONE);
            first = due_words.size();
            for (k = 0; k < SLOTS; k++) begin
               if (!shadow_valid[k] || k == shadow_idle) continue;
               shadow_rc[k] = sat32(((coef * shadow_rc[k]) >>> FRAC_BITS)
                                    + shadow_nice[k] * ONE);
               update_priority(k);
               push_word(k, 1, 0);
            end
            if (due_words.size() == first) push_word(0, 0, 1);
            else due_words[due_words.size() - 1].last = 1;
         end
         FUNC_SET_NICE: begin
            if (shadow_valid[s]) begin
               shadow_nice[s] = nv;
               update_priority(s);
            end
         end
         FUNC_RECOMPUTE: if (shadow_valid[s]) update_priority(s);
         FUNC_CREATE: begin
            shadow_valid[s] = 1;
            shadow_rc[s] = 0;
            shadow_nice[s] = 0;
            shadow_prio[s] = longint'(MIN_PRIO);
            update_priority(s);
         end
         FUNC_RETIRE: begin
            shadow_valid[s] = 0;
            shadow_rc[s] = 0;
            shadow_nice[s] = 0;
            shadow_prio[s] = 0;
         end
         default: ;
      endcase
      if (r.func != FUNC_TICK && r.func != FUNC_REFRESH && r.func != FUNC_NONE)
         push_word(s, 1, 1);
   endfunction

   // driver: bursts of requests with random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 0;
         gap_left <= 0;
         burst_left <= 0;
      end else begin
         if (start && !busy) begin
            account_request(cur);
            n_accepted++;
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 0;
            end else if (pending_reqs.size() > 0) begin
               cur = pending_reqs.pop_front();
               req_func <= cur.func;
               req_slot <= cur.slot;
               req_nice_value <= cur.nice;
               req_ready_count <= cur.count;
               start <= 1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 8);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               start <= 0;
            end
         end
      end
   end

   // monitor: compare every response word with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         n_words++;
         if (due_words.size() == 0) begin
            $display("%0t: unexpected word slot %0d", $time, rsp_out_slot);
            errors++;
         end else begin
            acct_word_type w;
            w = due_words.pop_front();
            if (w.slot !== rsp_out_slot) begin
               $display("%0t: slot exp %0d got %0d", $time, w.slot, rsp_out_slot);
               errors++;
            end
            if (w.prio !== rsp_out_priority) begin
               $display("%0t: priority exp %0d got %0d", $time, w.prio, rsp_out_priority);
               errors++;
            end
            if (w.rc_x100 !== rsp_recent_cpu_x100) begin
               $display("%0t: recent_cpu_x100 exp %0d got %0d", $time,
                        $signed(w.rc_x100), rsp_recent_cpu_x100);
               errors++;
            end
            if (w.load_x100 !== rsp_load_avg_x100) begin
               $display("%0t: load_avg_x100 exp %0d got %0d", $time,
                        w.load_x100, rsp_load_avg_x100);
               errors++;
            end
            if (w.last !== rsp_last) begin
               $display("%0t: last exp %0b got %0b", $time, w.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || reset || csr_wr_en) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 6000) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic void add_req(logic [2:0] f, int s, logic [5:0] nv, logic [6:0] c);
      acct_req_type r;
      r.func = f;
      r.slot = s[5:0];
      r.nice = nv;
      r.count = c;
      pending_reqs.push_back(r);
   endfunction

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || start || busy || due_words.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_idle(int v);
      csr_wr_en <= 1;
      csr_wr_data <= v[5:0];
      @(posedge clock);
      csr_wr_en <= 0;
      shadow_idle = v;
   endtask

   // mostly well-formed traffic on a small set of slots, plus noise
   task automatic random_phase(int n);
      int k, pick, s, lo;
      logic [5:0] nv;
      logic [6:0] c;
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
         if ($urandom_range(0, 15) == 0) s = shadow_idle;
         lo = int'($urandom_range(0, 40)) - 20;
         nv = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63)) : lo[5:0];
         c = 7'($urandom_range(0, 127));
         if (pick < 14)      add_req(FUNC_CREATE, s, nv, c);
         else if (pick < 46) add_req(FUNC_TICK, s, nv, c);
         else if (pick < 54) add_req(FUNC_REFRESH, s, nv,
                                     ($urandom_range(0, 4) == 0) ? 7'($urandom_range(65, 127))
                                                                 : 7'($urandom_range(0, 64)));
         else if (pick < 67) add_req(FUNC_SET_NICE, s, nv, c);
         else if (pick < 75) add_req(FUNC_RECOMPUTE, s, nv, c);
         else if (pick < 81) add_req(FUNC_RETIRE, s, nv, c);
         else if (pick < 96) add_req(FUNC_READ, s, nv, c);
         else                add_req(FUNC_NONE, s, nv, c);
      end
   endtask

   initial begin
      int k;
      errors = 0; n_accepted = 0; n_words = 0; n_refresh = 0; idle_cycles = 0;
      shadow_load = 0;
      shadow_idle = 0;
      for (k = 0; k < SLOTS; k++) begin
         shadow_valid[k] = 0; shadow_rc[k] = 0; shadow_nice[k] = 0; shadow_prio[k] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: empty refresh, invalid slots, idle slot, clamps, unused code
      add_req(FUNC_REFRESH, 0, 6'd0, 7'd0);
      add_req(FUNC_READ, 5, 6'd0, 7'd0);
      add_req(FUNC_SET_NICE, 9, 6'd5, 7'd0);
      add_req(FUNC_RECOMPUTE, 9, 6'd0, 7'd0);
      add_req(FUNC_CREATE, 0, 6'd0, 7'd0);
      add_req(FUNC_CREATE, 1, 6'd0, 7'd0);
      add_req(FUNC_CREATE, 2, 6'd0, 7'd0);
      add_req(FUNC_CREATE, 63, 6'd0, 7'd0);
      add_req(FUNC_TICK, 1, 6'd0, 7'd0);
      add_req(FUNC_TICK, 1, 6'd0, 7'd0);
      add_req(FUNC_TICK, 0, 6'd0, 7'd0);
      add_req(FUNC_TICK, 10, 6'd0, 7'd0);
      add_req(FUNC_SET_NICE, 1, 6'b100000, 7'd0);
      add_req(FUNC_SET_NICE, 2, 6'b011111, 7'd0);
      add_req(FUNC_SET_NICE, 63, 6'd20, 7'd0);
      add_req(FUNC_SET_NICE, 0, 6'b101100, 7'd0);
      add_req(FUNC_REFRESH, 0, 6'd0, 7'd127);
      add_req(FUNC_REFRESH, 0, 6'd0, 7'd64);
      add_req(FUNC_RECOMPUTE, 1, 6'd0, 7'd0);
      add_req(FUNC_RETIRE, 2, 6'd0, 7'd0);
      add_req(FUNC_READ, 2, 6'd0, 7'd0);
      add_req(FUNC_NONE, 3, 6'd0, 7'd0);
      add_req(FUNC_CREATE, 1, 6'd0, 7'd0);
      add_req(FUNC_READ, 63, 6'd0, 7'd0);
      drain();

      random_phase(85);
      drain();
      write_idle(63);
      random_phase(85);
      drain();
      write_idle($urandom_range(1, 62));
      random_phase(85);
      drain();
      write_idle(0);
      random_phase(85);
      drain();

      $display("covered %0d requests, %0d of them refreshes, %0d response words",
               n_accepted, n_refresh, n_words);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
